[rtl/v4a_pkg.sv]
// ----------------------------------------------------------------------------
// v4a_pkg
// Shared types, operation codes and saturation helpers for the four-component
// vector arithmetic unit (signed Q16.16).
// ----------------------------------------------------------------------------
package v4a_pkg;

  // Operation codes
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_NEG   = 4'd2;
  localparam logic [3:0] OP_SCALE = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_DOT   = 4'd5;
  localparam logic [3:0] OP_MAG   = 4'd6;
  localparam logic [3:0] OP_NORM  = 4'd7;
  localparam logic [3:0] OP_PROJ  = 4'd8;
  localparam logic [3:0] OP_REJ   = 4'd9;

  // Root bits and quotient bits produced, one per pipeline stage
  localparam int QBITS = 32;

  typedef logic [31:0] word_t;
  typedef word_t [3:0] vec_t;

  localparam word_t SAT_MAX = 32'h7fff_ffff;
  localparam word_t SAT_MIN = 32'h8000_0000;

  // Input transfer payload
  typedef struct packed {
    logic [3:0] operation;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      a_w;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
    word_t      b_w;
    word_t      factor;
  } cmd_t;

  // Output transfer payload
  typedef struct packed {
    word_t r_x;
    word_t r_y;
    word_t r_z;
    word_t r_w;
    word_t r_scalar;
    logic  fault;
  } rsp_t;

  // Item travelling down the pipeline, valid bit included
  typedef struct packed {
    logic        valid;
    logic [3:0]  op;
    vec_t        a;
    vec_t        b;
    word_t       f;
    vec_t        res;
    word_t       scal;
    logic        fault;
    logic [65:0] dab;   // dot(A,B), or sum of squares for magnitude ops
    logic [64:0] dbb;   // dot(B,B)
    logic [32:0] mag;   // unsaturated magnitude of A
  } item_t;

  // One divider lane
  typedef struct packed {
    logic [65:0] rem;
    logic [31:0] nlo;
    logic [31:0] quo;
    logic [64:0] den;
    logic        ovf;
    logic        zero;
    logic        neg;
  } div_lane_t;

  typedef div_lane_t [3:0] div_lanes_t;

  // Saturate a wide signed value to 32 bits
  function automatic word_t sat32(input logic signed [65:0] v);
    word_t r;
    if (v > 66'sd2147483647) begin
      r = SAT_MAX;
    end else if (v < -66'sd2147483648) begin
      r = SAT_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Divide by 2^16, rounding toward zero
  function automatic logic signed [65:0] trunc16(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v[65] ? v + 66'sd65535 : v;
    return t >>> 16;
  endfunction

endpackage

[rtl/v4a_stream_if.sv]
// ----------------------------------------------------------------------------
// v4a_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface v4a_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/vector4_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// vector4_arithmetic_unit
// Four-component signed Q16.16 vector ALU: add, sub, negate, scale, divide,
// dot, magnitude, normalize, project, reject.
//
//   channel | role   | payload                                  | handshake
//   --------+--------+------------------------------------------+------------
//   cmd     | input  | operation, a_x..a_w, b_x..b_w, factor    | valid/ready
//   rsp     | output | r_x..r_w, r_scalar, fault                | valid/ready
//
// One transfer accepted per cycle unless the skid slot is full; 3 product/sum
// stages, 32 square-root, 33 divider and 4 back-end stages, output reg.
// The per-bit root and quotient pipelines set the depth.
// Synchronous active-high reset clears all valid bits; no clearing pass.
// A stalled output parks one result in a skid register; the pipeline then
// holds until that slot drains, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module vector4_arithmetic_unit import v4a_pkg::*; (
  input logic            clk,
  input logic            rst,
  v4a_stream_if.sink     cmd,
  v4a_stream_if.source   rsp
);

  logic       en;
  item_t      front_out, sqrt_out, div_out;
  div_lanes_t lanes;
  logic       last_valid;
  rsp_t       last_data;
  logic       ov, sv;
  rsp_t       od, sd;
  logic       push;

  assign en        = !sv;
  assign cmd.ready = en;

  v4a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cmd_valid (cmd.valid),
    .cmd_data  (cmd.data),
    .dout      (front_out)
  );

  v4a_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (front_out),
    .dout (sqrt_out)
  );

  v4a_div u_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .din   (sqrt_out),
    .dout  (div_out),
    .lanes (lanes)
  );

  v4a_back u_back (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .din        (div_out),
    .lanes      (lanes),
    .dout_valid (last_valid),
    .dout       (last_data)
  );

  // Output register with skid slot
  assign push = last_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || rsp.ready) begin
      if (sv) begin
        ov <= 1'b1;
        od <= sd;
        sv <= 1'b0;
      end else if (push) begin
        ov <= 1'b1;
        od <= last_data;
      end else begin
        ov <= 1'b0;
      end
    end else if (push) begin
      sv <= 1'b1;
      sd <= last_data;
    end
  end

  assign rsp.valid = ov;
  assign rsp.data  = od;

  // Skid slot is only occupied behind a full output register
  a_skid_behind: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid slot full with output register empty");

  // Skid slot only fills on a stalled transfer
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(sv) |-> $past(ov && !rsp.ready))
    else $error("skid slot filled without a stall");

endmodule

[rtl/v4a_front.sv]
// ----------------------------------------------------------------------------
// v4a_front
// Three stages: component products, full-width sums, dot narrowing.
// Also resolves add, sub, negate and scale.
// ----------------------------------------------------------------------------
module v4a_front import v4a_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  cmd_valid,
  input  cmd_t  cmd_data,
  output item_t dout
);

  item_t s1, s1_next, s2, s2_next, s3, s3_next;
  logic signed [63:0] p [4];
  logic signed [63:0] q [4];
  logic signed [63:0] p_next [4];
  logic signed [63:0] q_next [4];
  word_t sel [4];

  // Stage 1: products and the simple element-wise ops
  always_comb begin
    s1_next       = '0;
    s1_next.valid = cmd_valid;
    s1_next.op    = cmd_data.operation;
    s1_next.a     = {cmd_data.a_w, cmd_data.a_z, cmd_data.a_y, cmd_data.a_x};
    s1_next.b     = {cmd_data.b_w, cmd_data.b_z, cmd_data.b_y, cmd_data.b_x};
    s1_next.f     = cmd_data.factor;
    for (int i = 0; i < 4; i++) begin
      if (s1_next.op == OP_SCALE) begin
        sel[i] = s1_next.f;
      end else if (s1_next.op == OP_MAG || s1_next.op == OP_NORM) begin
        sel[i] = s1_next.a[i];
      end else begin
        sel[i] = s1_next.b[i];
      end
      p_next[i] = $signed(s1_next.a[i]) * $signed(sel[i]);
      q_next[i] = $signed(s1_next.b[i]) * $signed(s1_next.b[i]);
      case (s1_next.op)
        OP_ADD: s1_next.res[i] = sat32(66'($signed(s1_next.a[i])) +
                                       66'($signed(s1_next.b[i])));
        OP_SUB: s1_next.res[i] = sat32(66'($signed(s1_next.a[i])) -
                                       66'($signed(s1_next.b[i])));
        OP_NEG: s1_next.res[i] = sat32(-66'($signed(s1_next.a[i])));
        default: s1_next.res[i] = '0;
      endcase
    end
  end

  // Stage 2: sums at full width, scale narrowing
  always_comb begin
    logic signed [65:0] sp, sq;
    s2_next = s1;
    sp = 66'(p[0]) + 66'(p[1]) + 66'(p[2]) + 66'(p[3]);
    sq = 66'(q[0]) + 66'(q[1]) + 66'(q[2]) + 66'(q[3]);
    s2_next.dab = sp;
    s2_next.dbb = sq[64:0];
    if (s1.op == OP_SCALE) begin
      for (int i = 0; i < 4; i++) begin
        s2_next.res[i] = sat32(trunc16(66'(p[i])));
      end
    end
  end

  // Stage 3: dot product to Q16.16
  always_comb begin
    s3_next = s2;
    if (s2.op == OP_DOT) begin
      s3_next.scal = sat32(trunc16($signed(s2.dab)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      for (int i = 0; i < 4; i++) begin
        p[i] <= p_next[i];
        q[i] <= q_next[i];
      end
    end
  end

  assign dout = s3;

endmodule

[rtl/v4a_sqrt.sv]
// ----------------------------------------------------------------------------
// v4a_sqrt
// Pipelined integer square root of the sum of squares, one root bit per
// stage. Fills in the magnitude and the magnitude scalar result.
// ----------------------------------------------------------------------------
module v4a_sqrt import v4a_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  item_t din,
  output item_t dout
);

  localparam logic [32:0] MAG_BIG = 33'h1_0000_0000;

  item_t       c_it [QBITS+1];
  logic [63:0] c_x  [QBITS+1];
  logic [34:0] c_r  [QBITS+1];
  logic [31:0] c_q  [QBITS+1];

  assign c_it[0] = din;
  assign c_x[0]  = din.dab[63:0];
  assign c_r[0]  = '0;
  assign c_q[0]  = '0;

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    item_t       it_reg, it_next;
    logic [63:0] x_reg;
    logic [34:0] r_reg, rs, trial;
    logic [31:0] q_reg, q_next;
    logic        fit;

    // Trial subtract of the next radicand bit pair
    assign rs     = {c_r[k][32:0], c_x[k][63:62]};
    assign trial  = {1'b0, c_q[k], 2'b01};
    assign fit    = rs >= trial;
    assign q_next = {c_q[k][30:0], fit};

    if (k == QBITS - 1) begin : g_last
      // Root complete: record magnitude, saturate the scalar
      always_comb begin
        it_next     = c_it[k];
        it_next.mag = c_it[k].dab[64] ? MAG_BIG : {1'b0, q_next};
        if (c_it[k].op == OP_MAG) begin
          it_next.scal = (c_it[k].dab[64] || q_next[31]) ? SAT_MAX : q_next;
        end
      end
    end else begin : g_mid
      assign it_next = c_it[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        it_reg.valid <= 1'b0;
      end else if (en) begin
        it_reg <= it_next;
        x_reg  <= {c_x[k][61:0], 2'b00};
        r_reg  <= fit ? rs - trial : rs;
        q_reg  <= q_next;
      end
    end

    assign c_it[k+1] = it_reg;
    assign c_x[k+1]  = x_reg;
    assign c_r[k+1]  = r_reg;
    assign c_q[k+1]  = q_reg;
  end

  assign dout = c_it[QBITS];

endmodule

[rtl/v4a_div.sv]
// ----------------------------------------------------------------------------
// v4a_div
// Four-lane pipelined restoring divider. A set-up stage picks numerator and
// divisor per operation and flags overflow; then one quotient bit per stage.
// ----------------------------------------------------------------------------
module v4a_div import v4a_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  item_t      din,
  output item_t      dout,
  output div_lanes_t lanes
);

  item_t      c_it [QBITS+2];
  div_lanes_t c_ln [QBITS+2];
  div_lanes_t set_next;

  function automatic word_t abs32(input word_t v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Set-up: operands per lane, divide-by-zero and quotient overflow
  always_comb begin
    logic [80:0] num;
    logic [65:0] dab_abs;
    dab_abs = din.dab[65] ? (~din.dab + 66'd1) : din.dab;
    for (int i = 0; i < 4; i++) begin
      num             = '0;
      set_next[i]     = '0;
      set_next[i].den = 65'd1;
      case (din.op)
        OP_DIV: begin
          num             = 81'({abs32(din.a[i]), 16'h0000});
          set_next[i].den = 65'(abs32(din.f));
          set_next[i].neg = din.a[i][31] ^ din.f[31];
        end
        OP_NORM: begin
          num             = 81'({abs32(din.a[i]), 16'h0000});
          set_next[i].den = 65'(din.mag);
          set_next[i].neg = din.a[i][31];
        end
        OP_PROJ, OP_REJ: begin
          if (i == 0) begin
            num             = {dab_abs[64:0], 16'h0000};
            set_next[i].den = din.dbb;
            set_next[i].neg = din.dab[65];
          end
        end
        default: begin
        end
      endcase
      set_next[i].zero = set_next[i].den == '0;
      set_next[i].ovf  = {16'h0000, num} >= {set_next[i].den, 32'h0000_0000};
      set_next[i].rem  = 66'(num[80:32]);
      set_next[i].nlo  = num[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_it[1].valid <= 1'b0;
    end else if (en) begin
      c_it[1] <= din;
      c_ln[1] <= set_next;
    end
  end

  assign c_it[0] = din;
  assign c_ln[0] = set_next;

  // One quotient bit per stage and lane
  for (genvar k = 1; k <= QBITS; k++) begin : g_stage
    div_lanes_t ln_next;

    always_comb begin
      logic [65:0] rs;
      logic        fit;
      for (int i = 0; i < 4; i++) begin
        ln_next[i]     = c_ln[k][i];
        rs             = {c_ln[k][i].rem[64:0], c_ln[k][i].nlo[31]};
        fit            = rs >= {1'b0, c_ln[k][i].den};
        ln_next[i].rem = fit ? rs - {1'b0, c_ln[k][i].den} : rs;
        ln_next[i].nlo = {c_ln[k][i].nlo[30:0], 1'b0};
        ln_next[i].quo = {c_ln[k][i].quo[30:0], fit};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        c_it[k+1].valid <= 1'b0;
      end else if (en) begin
        c_it[k+1] <= c_it[k];
        c_ln[k+1] <= ln_next;
      end
    end
  end

  assign dout  = c_it[QBITS+1];
  assign lanes = c_ln[QBITS+1];

endmodule

[rtl/v4a_back.sv]
// ----------------------------------------------------------------------------
// v4a_back
// Four stages: quotient narrowing, ratio times B, projection narrowing,
// rejection subtract. Forms the output payload.
// ----------------------------------------------------------------------------
module v4a_back import v4a_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  item_t      din,
  input  div_lanes_t lanes,
  output logic       dout_valid,
  output rsp_t       dout
);

  item_t b1, b1_next, b2, b3, b3_next, b4, b4_next;
  word_t ratio, ratio_next;
  logic signed [63:0] prod [4];

  // Signed, saturated 32-bit result from a lane's quotient magnitude
  function automatic word_t narrow(input div_lane_t l);
    word_t r;
    if (l.ovf) begin
      r = l.neg ? SAT_MIN : SAT_MAX;
    end else if (l.neg) begin
      r = (l.quo > 32'h8000_0000) ? SAT_MIN : (~l.quo + 32'd1);
    end else begin
      r = l.quo[31] ? SAT_MAX : l.quo;
    end
    return r;
  endfunction

  // Stage 1: narrow quotients, handle division by zero
  always_comb begin
    b1_next    = din;
    ratio_next = narrow(lanes[0]);
    case (din.op)
      OP_DIV: begin
        b1_next.fault = lanes[0].zero;
        for (int i = 0; i < 4; i++) begin
          if (lanes[0].zero) begin
            b1_next.res[i] = din.a[i][31] ? SAT_MIN :
                             ((din.a[i] != '0) ? SAT_MAX : '0);
          end else begin
            b1_next.res[i] = narrow(lanes[i]);
          end
        end
      end
      OP_NORM: begin
        b1_next.fault = lanes[0].zero;
        for (int i = 0; i < 4; i++) begin
          b1_next.res[i] = lanes[0].zero ? '0 : narrow(lanes[i]);
        end
      end
      OP_PROJ, OP_REJ: begin
        b1_next.fault = lanes[0].zero;
      end
      default: begin
      end
    endcase
  end

  // Stage 3: projection to Q16.16; zero vector B projects to zero
  always_comb begin
    b3_next = b2;
    if (b2.op == OP_PROJ || b2.op == OP_REJ) begin
      for (int i = 0; i < 4; i++) begin
        b3_next.res[i] = b2.fault ? '0 : sat32(trunc16(66'(prod[i])));
      end
    end
  end

  // Stage 4: rejection is A minus the projection
  always_comb begin
    b4_next = b3;
    if (b3.op == OP_REJ) begin
      for (int i = 0; i < 4; i++) begin
        b4_next.res[i] = sat32(66'($signed(b3.a[i])) - 66'($signed(b3.res[i])));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1.valid <= 1'b0;
      b2.valid <= 1'b0;
      b3.valid <= 1'b0;
      b4.valid <= 1'b0;
    end else if (en) begin
      b1    <= b1_next;
      ratio <= ratio_next;
      b2    <= b1;
      for (int i = 0; i < 4; i++) begin
        prod[i] <= $signed(b1.b[i]) * $signed(ratio);
      end
      b3 <= b3_next;
      b4 <= b4_next;
    end
  end

  assign dout_valid    = b4.valid;
  assign dout.r_x      = b4.res[0];
  assign dout.r_y      = b4.res[1];
  assign dout.r_z      = b4.res[2];
  assign dout.r_w      = b4.res[3];
  assign dout.r_scalar = b4.scal;
  assign dout.fault    = b4.fault;

  // Only the dividing operations can fault
  a_fault_ops: assert property (@(posedge clk) disable iff (rst)
    b4.valid && b4.fault |->
      (b4.op == OP_DIV || b4.op == OP_NORM || b4.op == OP_PROJ || b4.op == OP_REJ))
    else $error("fault raised by a non-dividing operation");

  // Scalar operations leave the vector clear
  a_scalar_vec: assert property (@(posedge clk) disable iff (rst)
    b4.valid && (b4.op == OP_DOT || b4.op == OP_MAG) |-> b4.res == '0 && !b4.fault)
    else $error("vector result set by a scalar operation");

  // The scalar is only produced by dot and magnitude
  a_scalar_ops: assert property (@(posedge clk) disable iff (rst)
    b4.valid && b4.scal != '0 |-> (b4.op == OP_DOT || b4.op == OP_MAG))
    else $error("scalar result set by a vector operation");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-component Q16.16 vector ALU. Directed
// corner items and constrained-by-hand random items are sent over the cmd
// channel with random gaps; results are drawn with random back-pressure,
// including one long hold-off, and compared field by field in a scoreboard
// that computes each expected result with a bit-exact arithmetic model.
// ----------------------------------------------------------------------------
module tb_top;
  import v4a_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] s128_t;

  // Expected-result store and checker
  class vec_alu_scoreboard;
    rsp_t pending[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    static function logic signed [31:0] clamp(input s128_t v);
      if (v > 128'sd2147483647) return 32'h7fff_ffff;
      if (v < -128'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    // Quotient rounded toward zero (SV signed division truncates)
    static function s128_t tdiv(input s128_t n, input s128_t d);
      return n / d;
    endfunction

    static function s128_t dot(input s128_t p[4], input s128_t q[4]);
      s128_t acc;
      acc = 0;
      for (int i = 0; i < 4; i++) acc += p[i] * q[i];
      return acc;
    endfunction

    static function s128_t root(input s128_t x);
      s128_t lo, hi, mid;
      lo = 0;
      hi = 128'sd8589934592;
      while (lo < hi) begin
        mid = (lo + hi + 1) >>> 1;
        if (mid * mid <= x) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    // Expected result of one command
    static function rsp_t compute(input cmd_t c);
      rsp_t  r;
      s128_t a[4], b[4], f, m, dab, dbb, t;
      logic signed [31:0] v[4];
      logic  flt;
      a[0] = $signed(c.a_x); a[1] = $signed(c.a_y);
      a[2] = $signed(c.a_z); a[3] = $signed(c.a_w);
      b[0] = $signed(c.b_x); b[1] = $signed(c.b_y);
      b[2] = $signed(c.b_z); b[3] = $signed(c.b_w);
      f = $signed(c.factor);
      for (int i = 0; i < 4; i++) v[i] = 0;
      flt = 0;
      r.r_scalar = 0;
      case (c.operation)
        OP_ADD:   for (int i = 0; i < 4; i++) v[i] = clamp(a[i] + b[i]);
        OP_SUB:   for (int i = 0; i < 4; i++) v[i] = clamp(a[i] - b[i]);
        OP_NEG:   for (int i = 0; i < 4; i++) v[i] = clamp(-a[i]);
        OP_SCALE: for (int i = 0; i < 4; i++) v[i] = clamp(tdiv(a[i] * f, 65536));
        OP_DIV: begin
          for (int i = 0; i < 4; i++) begin
            if (f == 0) begin
              flt = 1;
              v[i] = a[i] > 0 ? 32'h7fff_ffff : (a[i] < 0 ? 32'h8000_0000 : 0);
            end else begin
              v[i] = clamp(tdiv(a[i] * 65536, f));
            end
          end
        end
        OP_DOT:   r.r_scalar = clamp(tdiv(dot(a, b), 65536));
        OP_MAG:   r.r_scalar = clamp(root(dot(a, a)));
        OP_NORM: begin
          m = root(dot(a, a));
          if (m == 0) flt = 1;
          else for (int i = 0; i < 4; i++) v[i] = clamp(tdiv(a[i] * 65536, m));
        end
        OP_PROJ, OP_REJ: begin
          dab = dot(a, b);
          dbb = dot(b, b);
          if (dbb == 0) flt = 1;
          else begin
            t = $signed(clamp(tdiv(dab * 65536, dbb)));
            for (int i = 0; i < 4; i++) v[i] = clamp(tdiv(b[i] * t, 65536));
          end
          if (c.operation == OP_REJ)
            for (int i = 0; i < 4; i++) v[i] = clamp(a[i] - s128_t'(v[i]));
        end
        default: ;
      endcase
      r.r_x = v[0]; r.r_y = v[1]; r.r_z = v[2]; r.r_w = v[3];
      r.fault = flt;
      return r;
    endfunction

    function void note_command(input cmd_t c);
      pending.push_back(compute(c));
    endfunction

    function void check_result(input rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.r_x !== want.r_x) report("r_x", want.r_x, got.r_x);
      if (got.r_y !== want.r_y) report("r_y", want.r_y, got.r_y);
      if (got.r_z !== want.r_z) report("r_z", want.r_z, got.r_z);
      if (got.r_w !== want.r_w) report("r_w", want.r_w, got.r_w);
      if (got.r_scalar !== want.r_scalar) report("r_scalar", want.r_scalar, got.r_scalar);
      if (got.fault !== want.fault) report("fault", want.fault, got.fault);
    endfunction

    function void report(input string fld, input logic [31:0] want, input logic [31:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  int   cycle = 0;
  bit   hold_off = 0;
  bit   sending_done = 0;
  vec_alu_scoreboard sb = new();

  v4a_stream_if #(.payload_t(cmd_t)) cmd ();
  v4a_stream_if #(.payload_t(rsp_t)) rsp ();

  vector4_arithmetic_unit dut (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle <= cycle + 1;

  initial begin
    cmd.valid = 0;
    cmd.data  = '0;
    rsp.ready = 0;
  end

  // Scoreboard hooks on every transfer
  always @(posedge clk) begin
    if (!rst && cmd.valid && cmd.ready) sb.note_command(cmd.data);
    if (!rst && rsp.valid && rsp.ready) sb.check_result(rsp.data);
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return 0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      4, 5: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
      6: return $urandom & 32'h00ff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Sends one command, holding valid until the transfer
  task automatic send_cmd(input cmd_t c);
    int g;
    g = gap_len();
    if (g > 0) begin
      cmd.valid <= 0;
      repeat (g) @(posedge clk);
    end
    cmd.valid <= 1;
    cmd.data  <= c;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  function automatic cmd_t mk(input logic [3:0] op, input word_t a, input word_t b,
                              input word_t f);
    cmd_t c;
    c.operation = op;
    c.a_x = a; c.a_y = a; c.a_z = a; c.a_w = a;
    c.b_x = b; c.b_y = b; c.b_z = b; c.b_w = b;
    c.factor = f;
    return c;
  endfunction

  // Receiver with random stalls and one long hold-off
  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) rsp.ready <= 0;
      else if ($urandom_range(0, 99) < 30) begin
        g = gap_len();
        if (g > 0) begin
          rsp.ready <= 0;
          repeat (g) @(posedge clk);
        end
        rsp.ready <= 1;
      end else rsp.ready <= 1;
    end
  end

  initial begin
    int hold_cnt;
    @(negedge rst);
    repeat (300) @(posedge clk);
    hold_off = 1;
    for (hold_cnt = 0; hold_cnt < 400; hold_cnt++) @(posedge clk);
    hold_off = 0;
  end

  // Stimulus
  initial begin
    cmd_t c;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed corners
    send_cmd(mk(OP_ADD, SAT_MAX, SAT_MAX, 0));
    send_cmd(mk(OP_SUB, SAT_MIN, SAT_MAX, 0));
    send_cmd(mk(OP_NEG, SAT_MIN, 0, 0));
    send_cmd(mk(OP_SCALE, SAT_MIN, 0, SAT_MIN));
    send_cmd(mk(OP_SCALE, 32'h0003_0000, 0, 32'hffff_8000));
    send_cmd(mk(OP_DIV, 32'h0001_0000, 0, 0));
    send_cmd(mk(OP_DIV, SAT_MIN, 0, 0));
    send_cmd(mk(OP_DIV, 0, 0, 0));
    send_cmd(mk(OP_DIV, SAT_MAX, 0, 32'h0000_0001));
    send_cmd(mk(OP_DOT, SAT_MIN, SAT_MIN, 0));
    send_cmd(mk(OP_DOT, SAT_MAX, SAT_MIN, 0));
    send_cmd(mk(OP_MAG, SAT_MIN, 0, 0));
    send_cmd(mk(OP_MAG, 32'h0001_0000, 0, 0));
    send_cmd(mk(OP_NORM, 0, 0, 0));
    send_cmd(mk(OP_NORM, SAT_MIN, 0, 0));
    send_cmd(mk(OP_NORM, 32'h0000_0001, 0, 0));
    send_cmd(mk(OP_PROJ, 32'h0002_0000, 0, 0));
    send_cmd(mk(OP_PROJ, SAT_MAX, 32'h0000_0001, 0));
    send_cmd(mk(OP_REJ, SAT_MIN, 0, 0));
    send_cmd(mk(OP_REJ, SAT_MIN, 32'h0000_0001, 0));
    send_cmd(mk(OP_REJ, 32'h0001_0000, 32'hffff_0000, 0));
    send_cmd(mk(4'd10, SAT_MAX, SAT_MAX, SAT_MAX));
    send_cmd(mk(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    // random part
    for (int n = 0; n < 1650; n++) begin
      c.operation = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9));
      c.a_x = rand_word(); c.a_y = rand_word(); c.a_z = rand_word(); c.a_w = rand_word();
      c.b_x = rand_word(); c.b_y = rand_word(); c.b_z = rand_word(); c.b_w = rand_word();
      c.factor = rand_word();
      if ($urandom_range(0, 15) == 0) {c.b_x, c.b_y, c.b_z, c.b_w} = '0;
      if ($urandom_range(0, 15) == 0) {c.a_x, c.a_y, c.a_z, c.a_w} = '0;
      send_cmd(c);
    end
    cmd.valid <= 0;
    sending_done = 1;
  end

  // End of run
  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0 && cycle < 200000) @(posedge clk);
    repeat (150) @(posedge clk);
    if (cycle >= 200000) $display("tb_top: errors");
    else if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  // Watchdog
  initial begin
    wait (cycle >= 250000);
    $display("tb_top: errors");
    $finish;
  end

endmodule

[vector4_arithmetic_unit.f]
rtl/v4a_pkg.sv
rtl/v4a_stream_if.sv
rtl/v4a_front.sv
rtl/v4a_sqrt.sv
rtl/v4a_div.sv
rtl/v4a_back.sv
rtl/vector4_arithmetic_unit.sv
tb/tb_top.sv
